>>> hw/rtl/mcbar_pkg.sv
// Package for the multi-cell bridge converter reader.
// Holds the fixed sample width, the line count, register indexes and the control struct.
// No dependencies.
package mcbar_pkg;

	localparam int SAMPLE_BITS = 24;
	localparam int LINE_COUNT = 8;
	localparam int PHASE_W = 7;
	localparam int BITPOS_W = 5;
	localparam int COUNT_W = 4;
	localparam int GAIN_W = 2;
	localparam int CFG_DATA_W = 8;
	localparam int CFG_INDEX_W = 2;
	localparam int CELL_IDX_W = 3;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_CELL_COUNT   = 2'd0,
		REG_PRESENT_MASK = 2'd1,
		REG_GAIN_PULSES  = 2'd2
	} reg_index_t;

	typedef struct packed {
		logic                sck;
		logic                sample_en;
		logic [BITPOS_W-1:0] bitpos;
		logic                frame_end;
	} ctrl_t;

endpackage

>>> hw/rtl/mcbar_seq.sv
// Frame sequencer: phase counter, clock level, readiness check and frame end.
// Depends on mcbar_pkg.
module mcbar_seq (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  step_en,
	input  logic [mcbar_pkg::LINE_COUNT-1:0]      dout_lines,
	input  logic [mcbar_pkg::LINE_COUNT-1:0]      present_mask,
	input  logic [mcbar_pkg::LINE_COUNT-1:0]      active_mask,
	input  logic [mcbar_pkg::GAIN_W-1:0]          gain_pulses,
	output mcbar_pkg::ctrl_t                      ctrl
);

	localparam logic [mcbar_pkg::PHASE_W-1:0] DATA_HALVES =
		mcbar_pkg::PHASE_W'(2 * mcbar_pkg::SAMPLE_BITS);

	logic [mcbar_pkg::PHASE_W-1:0] phase_q;
	logic [mcbar_pkg::PHASE_W-1:0] end_phase;
	logic                          idle;
	logic                          lines_ready;

	assign idle = (phase_q == '0);
	assign end_phase = DATA_HALVES + {(mcbar_pkg::PHASE_W-1)'(gain_pulses), 1'b0};
	assign lines_ready = ~|(present_mask & active_mask & dout_lines);

	always_comb begin
		ctrl.sck = phase_q[0];
		ctrl.sample_en = !idle && phase_q[0] && (phase_q < DATA_HALVES);
		ctrl.bitpos = mcbar_pkg::BITPOS_W'(mcbar_pkg::SAMPLE_BITS - 1)
			- phase_q[mcbar_pkg::BITPOS_W:1];
		ctrl.frame_end = !idle && !phase_q[0] && (phase_q >= end_phase);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
		end else if (step_en) begin
			if (idle) begin
				phase_q <= lines_ready ? mcbar_pkg::PHASE_W'(1) : '0;
			end else if (ctrl.frame_end) begin
				phase_q <= '0;
			end else begin
				phase_q <= phase_q + mcbar_pkg::PHASE_W'(1);
			end
		end
	end

endmodule

>>> hw/rtl/mcbar_lane.sv
// One cell lane: shifts its data-out line into a 24-bit reading, MSB first.
// Depends on mcbar_pkg.
module mcbar_lane (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               step_en,
	input  mcbar_pkg::ctrl_t                   ctrl,
	input  logic                               active,
	input  logic                               present,
	input  logic                               line,
	output logic [mcbar_pkg::SAMPLE_BITS-1:0]  value
);

	logic [mcbar_pkg::SAMPLE_BITS-1:0] shifter_q;
	logic                              bit_in;

	// An absent cell shifts in the pattern of the most negative reading.
	assign bit_in = present ? line
		: (ctrl.bitpos == mcbar_pkg::BITPOS_W'(mcbar_pkg::SAMPLE_BITS - 1));
	assign value = shifter_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shifter_q <= '0;
		end else if (step_en && ctrl.sample_en && active) begin
			shifter_q[ctrl.bitpos] <= bit_in;
		end
	end

endmodule

>>> hw/rtl/mcbar_merge.sv
// Output stage: holds the tick result, or walks the lane readings at frame end.
// Depends on mcbar_pkg.
module mcbar_merge #(
	parameter int LANES = 8
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    step_en,
	input  mcbar_pkg::ctrl_t                        ctrl,
	input  logic [mcbar_pkg::COUNT_W-1:0]           n_cells,
	input  logic [mcbar_pkg::SAMPLE_BITS-1:0]       lane_values [LANES],
	output logic                                    in_ready,
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output logic                                    sck_level,
	output logic                                    sample_valid,
	output logic [mcbar_pkg::CELL_IDX_W-1:0]        cell_index,
	output logic signed [mcbar_pkg::SAMPLE_BITS-1:0] sample_value,
	output logic                                    last_cell
);

	localparam int IDX_W = (LANES > 1) ? $clog2(LANES) : 1;

	logic                              valid_q;
	logic                              burst_q;
	logic                              sck_q;
	logic [IDX_W-1:0]                  idx_q;
	logic [mcbar_pkg::COUNT_W-1:0]     n_q;
	logic                              is_last;
	logic [mcbar_pkg::SAMPLE_BITS-1:0] sel_value;

	assign is_last = ({{(mcbar_pkg::COUNT_W + 1 - IDX_W){1'b0}}, idx_q}
		+ (mcbar_pkg::COUNT_W + 1)'(1)) == {1'b0, n_q};

	always_comb begin
		sel_value = '0;
		for (int i = 0; i < LANES; i++) begin
			if (idx_q == IDX_W'(i)) begin
				sel_value = lane_values[i];
			end
		end
	end

	assign in_ready = !valid_q || (out_ready && (!burst_q || is_last));
	assign out_valid = valid_q;
	assign sck_level = burst_q ? 1'b0 : sck_q;
	assign sample_valid = burst_q;
	assign cell_index = burst_q ? mcbar_pkg::CELL_IDX_W'(idx_q) : '0;
	assign sample_value = burst_q ? $signed(sel_value) : '0;
	assign last_cell = burst_q && is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			burst_q <= 1'b0;
			idx_q <= '0;
		end else if (step_en) begin
			valid_q <= 1'b1;
			idx_q <= '0;
			burst_q <= ctrl.frame_end && (n_cells != '0);
		end else if (valid_q && out_ready) begin
			if (burst_q && !is_last) begin
				idx_q <= idx_q + IDX_W'(1);
			end else begin
				valid_q <= 1'b0;
				burst_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step_en) begin
			sck_q <= ctrl.sck;
			n_q <= n_cells;
		end
	end

endmodule

>>> hw/rtl/multi_cell_bridge_adc_reader.sv
// Multi-cell bridge converter reader on one shared serial clock, one lane per cell.
// Output: a tick's result is registered and presented in the cycle after the item is accepted.
// Throughput: one tick per cycle while out_ready is high; a frame-end tick holds the input
// while the lane readings are presented in order by the output stage.
// Reset: asynchronous, active low; idle phase, config at defaults; clock output not reset.
// Depends on mcbar_pkg, mcbar_seq, mcbar_lane and mcbar_merge.
module multi_cell_bridge_adc_reader #(
	parameter int MAX_CELLS = 8
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     cfg_we,
	input  logic [mcbar_pkg::CFG_INDEX_W-1:0]        cfg_index,
	input  logic [mcbar_pkg::CFG_DATA_W-1:0]         cfg_data,
	input  logic                                     in_valid,
	output logic                                     in_ready,
	input  logic [mcbar_pkg::LINE_COUNT-1:0]         dout_lines,
	output logic                                     out_valid,
	input  logic                                     out_ready,
	output logic                                     sck_level,
	output logic                                     sample_valid,
	output logic [mcbar_pkg::CELL_IDX_W-1:0]         cell_index,
	output logic signed [mcbar_pkg::SAMPLE_BITS-1:0] sample_value,
	output logic                                     last_cell
);

	localparam int LANES = (MAX_CELLS < mcbar_pkg::LINE_COUNT) ? MAX_CELLS
		: mcbar_pkg::LINE_COUNT;

	logic [mcbar_pkg::COUNT_W-1:0]     cell_count_q;
	logic [mcbar_pkg::LINE_COUNT-1:0]  present_mask_q;
	logic [mcbar_pkg::GAIN_W-1:0]      gain_pulses_q;
	logic [mcbar_pkg::COUNT_W-1:0]     n_cells;
	logic [mcbar_pkg::LINE_COUNT-1:0]  active_mask;
	logic                              step_en;
	mcbar_pkg::ctrl_t                  ctrl;
	logic [mcbar_pkg::SAMPLE_BITS-1:0] lane_values [LANES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_count_q <= mcbar_pkg::COUNT_W'(8);
			present_mask_q <= '1;
			gain_pulses_q <= mcbar_pkg::GAIN_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				mcbar_pkg::REG_CELL_COUNT: begin
					cell_count_q <= cfg_data[mcbar_pkg::COUNT_W-1:0];
				end
				mcbar_pkg::REG_PRESENT_MASK: begin
					present_mask_q <= cfg_data[mcbar_pkg::LINE_COUNT-1:0];
				end
				mcbar_pkg::REG_GAIN_PULSES: begin
					gain_pulses_q <= cfg_data[mcbar_pkg::GAIN_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign n_cells = (cell_count_q < mcbar_pkg::COUNT_W'(LANES)) ? cell_count_q
		: mcbar_pkg::COUNT_W'(LANES);

	always_comb begin
		for (int i = 0; i < mcbar_pkg::LINE_COUNT; i++) begin
			active_mask[i] = (mcbar_pkg::COUNT_W'(i) < n_cells);
		end
	end

	assign step_en = in_valid && in_ready;

	mcbar_seq u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.step_en      (step_en),
		.dout_lines   (dout_lines),
		.present_mask (present_mask_q),
		.active_mask  (active_mask),
		.gain_pulses  (gain_pulses_q),
		.ctrl         (ctrl)
	);

	for (genvar g = 0; g < LANES; g++) begin : g_lane
		mcbar_lane u_lane (
			.clk     (clk),
			.arst_n  (arst_n),
			.step_en (step_en),
			.ctrl    (ctrl),
			.active  (active_mask[g]),
			.present (present_mask_q[g]),
			.line    (dout_lines[g]),
			.value   (lane_values[g])
		);
	end

	mcbar_merge #(
		.LANES (LANES)
	) u_merge (
		.clk          (clk),
		.arst_n       (arst_n),
		.step_en      (step_en),
		.ctrl         (ctrl),
		.n_cells      (n_cells),
		.lane_values  (lane_values),
		.in_ready     (in_ready),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.sck_level    (sck_level),
		.sample_valid (sample_valid),
		.cell_index   (cell_index),
		.sample_value (sample_value),
		.last_cell    (last_cell)
	);

endmodule
